// ===== rtl/ltms_pkg.sv =====
// Package for the loser tree merge selector: widths, codes, state and control types.
package ltms_pkg;

  // Default number of merge ways the tree storage is sized for
  localparam int MAX_WAYS_DEF = 16;

  // Fixed field widths
  localparam int KEY_W = 32;
  localparam int WAY_W = 4;
  localparam int CFG_W = 5;

  // Active way count after reset
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

  // Drain sentinel: a way holding this key has run dry
  localparam logic signed [KEY_W-1:0] KEY_SENTINEL = 32'sh7FFF_FFFF;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_BUILD   = 2'd1,
    OP_REPLACE = 2'd2
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_LEFT,
    ST_BLD_RIGHT,
    ST_BLD_CMP,
    ST_RPL_FETCH,
    ST_RPL_CMP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic key_wr;        // write key_i into the key memory
    logic key_at_winner; // key write address is the current overall winner
    logic init;          // set up a build or a replay
    logic fetch_l;       // fetch left child winner of the current node
    logic fetch_r;       // fetch right child winner of the current node
    logic build_cmp;     // compare both children, store node winner and loser
    logic repl_fetch;    // fetch the stored loser of the next node up the path
    logic repl_cmp;      // compare stored loser against the climbing way
    logic finish;        // capture the result and the overall winner
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic way_ok;         // load way lies inside the key memory
    logic winner_outside; // overall winner is beyond the active way count
    logic last_node;      // current node is the root
  } stat_t;

endpackage

// ===== rtl/ltms_ctrl.sv =====
// Controller state machine of the loser tree merge selector.
module ltms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ltms_pkg::stat_t     stat_i,
  output ltms_pkg::cmd_t      cmd_o
);

  ltms_pkg::state_e state_q, state_d;
  ltms_pkg::op_e    op;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             can_finish;

  assign op         = ltms_pkg::op_e'(operation_i);
  assign in_ready_o = (state_q == ltms_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The result register is free, or empties in this cycle
  assign can_finish = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ltms_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            ltms_pkg::OP_BUILD: begin
              state_d = ltms_pkg::ST_BLD_LEFT;
            end
            ltms_pkg::OP_REPLACE: begin
              state_d = stat_i.winner_outside ? ltms_pkg::ST_BLD_LEFT
                                              : ltms_pkg::ST_RPL_FETCH;
            end
            default: begin
              state_d = ltms_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ltms_pkg::ST_BLD_LEFT: begin
        state_d = ltms_pkg::ST_BLD_RIGHT;
      end
      ltms_pkg::ST_BLD_RIGHT: begin
        state_d = ltms_pkg::ST_BLD_CMP;
      end
      ltms_pkg::ST_BLD_CMP: begin
        if (!stat_i.last_node) begin
          state_d = ltms_pkg::ST_BLD_LEFT;
        end else if (can_finish) begin
          state_d = ltms_pkg::ST_IDLE;
        end
      end
      ltms_pkg::ST_RPL_FETCH: begin
        state_d = ltms_pkg::ST_RPL_CMP;
      end
      ltms_pkg::ST_RPL_CMP: begin
        if (!stat_i.last_node) begin
          state_d = ltms_pkg::ST_RPL_FETCH;
        end else if (can_finish) begin
          state_d = ltms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ltms_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ltms_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            ltms_pkg::OP_LOAD: begin
              cmd_o.key_wr = stat_i.way_ok;
            end
            ltms_pkg::OP_BUILD: begin
              cmd_o.init = 1'b1;
            end
            ltms_pkg::OP_REPLACE: begin
              cmd_o.key_wr        = 1'b1;
              cmd_o.key_at_winner = 1'b1;
              cmd_o.init          = 1'b1;
            end
            default: begin
              cmd_o = '0;
            end
          endcase
        end
      end
      ltms_pkg::ST_BLD_LEFT: begin
        cmd_o.fetch_l = 1'b1;
      end
      ltms_pkg::ST_BLD_RIGHT: begin
        cmd_o.fetch_r = 1'b1;
      end
      ltms_pkg::ST_BLD_CMP: begin
        // Hold at the root until the result register can take the transaction
        if (!stat_i.last_node || can_finish) begin
          cmd_o.build_cmp = 1'b1;
          cmd_o.finish    = stat_i.last_node;
        end
      end
      ltms_pkg::ST_RPL_FETCH: begin
        cmd_o.repl_fetch = 1'b1;
      end
      ltms_pkg::ST_RPL_CMP: begin
        if (!stat_i.last_node || can_finish) begin
          cmd_o.repl_cmp = 1'b1;
          cmd_o.finish   = stat_i.last_node;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Result valid: set on finish, drop when taken
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ltms_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A finish never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still pending");

  // A new result only comes from a compare at the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($past(state_q) == ltms_pkg::ST_BLD_CMP || $past(state_q) == ltms_pkg::ST_RPL_CMP))
    else $error("result raised outside a root compare");

  // A replay compare always follows the fetch of its stored loser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.repl_cmp |-> $past(state_q) == ltms_pkg::ST_RPL_FETCH
                       || $past(state_q) == ltms_pkg::ST_RPL_CMP)
    else $error("replay compare without a loser fetch");

endmodule

// ===== rtl/ltms_dpath.sv =====
// Datapath of the loser tree merge selector: key memory, node storage, comparator.
module ltms_dpath #(
  parameter int MaxWays = ltms_pkg::MAX_WAYS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [ltms_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [ltms_pkg::WAY_W-1:0]           way_i,
  input  logic signed [ltms_pkg::KEY_W-1:0]    key_i,
  input  ltms_pkg::cmd_t                       cmd_i,
  output ltms_pkg::stat_t                      stat_o,
  output logic [ltms_pkg::WAY_W-1:0]           winner_way_o,
  output logic signed [ltms_pkg::KEY_W-1:0]    winner_key_o,
  output logic                                 exhausted_o
);

  localparam int WayW    = $clog2(MaxWays);
  localparam int PosW    = WayW + 1;
  localparam int WayOutW = ltms_pkg::WAY_W;
  localparam int CfgW    = ltms_pkg::CFG_W;

  logic [CfgW-1:0]                      active_q;
  logic [PosW-1:0]                      n_ways;

  logic signed [ltms_pkg::KEY_W-1:0]    keys_mem [MaxWays];
  logic signed [ltms_pkg::KEY_W-1:0]    ka_q, kb_q;
  logic [WayW-1:0]                      key_waddr;

  logic [WayW-1:0]                      loser_q [MaxWays];
  logic [WayW-1:0]                      nwin_q  [MaxWays];
  logic [WayW-1:0]                      overall_q;

  logic [WayW-1:0]                      node_q;
  logic [PosW-1:0]                      pos_q;
  logic [WayW-1:0]                      cur_q;
  logic signed [ltms_pkg::KEY_W-1:0]    curkey_q;
  logic [WayW-1:0]                      ia_q, ia_d, ib_q, ib_d;

  logic [PosW-1:0]                      child_pos;
  logic [WayW-1:0]                      child_way;
  logic [WayW-1:0]                      repl_node;
  logic [WayW-1:0]                      kept_way;

  logic [WayW-1:0]                      b_way;
  logic signed [ltms_pkg::KEY_W-1:0]    b_key;
  logic                                 a_wins;
  logic [WayW-1:0]                      win_way, lose_way;
  logic signed [ltms_pkg::KEY_W-1:0]    win_key;

  logic [WayW-1:0]                      out_way_q;
  logic signed [ltms_pkg::KEY_W-1:0]    out_key_q;
  logic                                 out_exh_q;

  // Active way count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ltms_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Clamp the way count into the supported range
  always_comb begin
    if (active_q < CfgW'(2)) begin
      n_ways = PosW'(2);
    end else if (int'(active_q) > MaxWays) begin
      n_ways = PosW'(MaxWays);
    end else begin
      n_ways = PosW'(active_q);
    end
  end

  // Child of the current build node: a leaf way or a lower node's winner
  assign child_pos = {node_q, cmd_i.fetch_r};
  assign child_way = (child_pos >= n_ways) ? WayW'(child_pos - n_ways)
                                           : nwin_q[child_pos[WayW-1:0]];

  // Next node up the replay path and its stored loser
  assign repl_node = pos_q[PosW-1:1];
  assign kept_way  = loser_q[repl_node];

  // Compare operand selects
  always_comb begin
    priority if (cmd_i.fetch_l) begin
      ia_d = child_way;
    end else if (cmd_i.repl_fetch) begin
      ia_d = kept_way;
    end else begin
      ia_d = ia_q;
    end
  end

  assign ib_d = cmd_i.fetch_r ? child_way : ib_q;

  // Key memory: one write port, two registered read ports
  assign key_waddr = cmd_i.key_at_winner ? overall_q : WayW'(way_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) begin
      keys_mem[key_waddr] <= key_i;
    end
    ka_q <= keys_mem[ia_d];
    kb_q <= keys_mem[ib_d];
  end

  // Shared comparator: operand a wins ties (left child on build, stored loser on replay)
  assign b_way    = cmd_i.build_cmp ? ib_q : cur_q;
  assign b_key    = cmd_i.build_cmp ? kb_q : curkey_q;
  assign a_wins   = (ka_q <= b_key);
  assign win_way  = a_wins ? ia_q : b_way;
  assign win_key  = a_wins ? ka_q : b_key;
  assign lose_way = a_wins ? b_way : ia_q;

  // Walk state, node winners and result payload
  always_ff @(posedge clk_i) begin
    ia_q <= ia_d;
    ib_q <= ib_d;
    if (cmd_i.init) begin
      node_q   <= WayW'(n_ways - PosW'(1));
      cur_q    <= overall_q;
      curkey_q <= key_i;
      pos_q    <= n_ways + PosW'(overall_q);
    end
    if (cmd_i.repl_fetch) begin
      node_q <= repl_node;
    end
    if (cmd_i.build_cmp) begin
      nwin_q[node_q] <= win_way;
      node_q         <= node_q - WayW'(1);
    end
    if (cmd_i.repl_cmp) begin
      cur_q    <= win_way;
      curkey_q <= win_key;
      pos_q    <= PosW'(node_q);
    end
    if (cmd_i.finish) begin
      out_way_q <= win_way;
      out_key_q <= win_key;
      out_exh_q <= (win_key == ltms_pkg::KEY_SENTINEL);
    end
  end

  // Losers and the overall winner start at way zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overall_q <= '0;
      for (int i = 0; i < MaxWays; i++) begin
        loser_q[i] <= '0;
      end
    end else begin
      if (cmd_i.build_cmp || cmd_i.repl_cmp) begin
        loser_q[node_q] <= lose_way;
      end
      if (cmd_i.finish) begin
        overall_q <= win_way;
      end
    end
  end

  // Status to the controller
  assign stat_o.way_ok         = (int'(way_i) < MaxWays);
  assign stat_o.winner_outside = (PosW'(overall_q) >= n_ways);
  assign stat_o.last_node      = (node_q == WayW'(1));

  assign winner_way_o = WayOutW'(out_way_q);
  assign winner_key_o = out_key_q;
  assign exhausted_o  = out_exh_q;

endmodule

// ===== rtl/loser_tree_merge_selector_top.sv =====
// Loser tree merge selector top level: K-way minimum selection over signed keys.
// Load stores one key. Build: two child fetches and one compare per internal node on a
// shared comparator, N - 1 internal nodes for N active ways. Replace: L levels of loser
// fetch and compare, L = floor(log2(N + winner)), or a full build if the winner is outside
// the active ways. One transaction at a time; result valid after the root compare, which
// holds while an earlier result waits. Reset: control, node losers, winner to 0, N = 8.
module loser_tree_merge_selector_top #(
  parameter int MaxWays = ltms_pkg::MAX_WAYS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           operation_i,
  input  logic [ltms_pkg::WAY_W-1:0]           way_i,
  input  logic signed [ltms_pkg::KEY_W-1:0]    key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ltms_pkg::WAY_W-1:0]           winner_way_o,
  output logic signed [ltms_pkg::KEY_W-1:0]    winner_key_o,
  output logic                                 exhausted_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ltms_pkg::CFG_W-1:0]           cfg_data_i
);

  ltms_pkg::cmd_t  cmd;
  ltms_pkg::stat_t stat;

  // The register write is always taken
  assign cfg_ready_o = 1'b1;

  ltms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ltms_dpath #(
    .MaxWays (MaxWays)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .way_i        (way_i),
    .key_i        (key_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .winner_way_o (winner_way_o),
    .winner_key_o (winner_key_o),
    .exhausted_o  (exhausted_o)
  );

endmodule

// ===== tb/tb_loser_tree_merge_selector_top.sv =====
// Testbench for the loser tree merge selector: directed and random merges checked against a predictor.
`timescale 1ns / 1ps

module tb_loser_tree_merge_selector_top;

  localparam int MaxWays = ltms_pkg::MAX_WAYS_DEF;
  localparam int KeyW = ltms_pkg::KEY_W;
  localparam int WayW = ltms_pkg::WAY_W;
  localparam int CfgW = ltms_pkg::CFG_W;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KeyW-1:0] KEY_MIN = 32'sh8000_0000;
  // longest idle stretch of the block after its last result
  localparam int DrainCycles = 64;
  localparam int PhaseItems = 80;
  localparam int NumPhases = 9;

  typedef enum int {
    SPREAD_NARROW,
    SPREAD_WIDE,
    SPREAD_EDGES
  } key_spread_e;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH_LIGHT
  } pace_e;

  typedef struct packed {
    logic [WayW-1:0]        way;
    logic signed [KeyW-1:0] key;
    logic                   exh;
  } merge_result_t;

  // Tree predictor plus the queue of winners still owed by the block
  class winner_scoreboard;
    logic signed [KeyW-1:0] keys [MaxWays];
    logic [WayW-1:0]        losers [MaxWays];
    logic [WayW-1:0]        winners [MaxWays];
    logic [WayW-1:0]        root;
    logic [CfgW-1:0]        ways_reg;
    merge_result_t          pending_winners [$];
    int                     mismatches;
    int                     inputs_taken;
    int                     results_checked;
    int                     exhausted_checked;

    function new();
      foreach (keys[i]) begin
        keys[i]    = '0;
        losers[i]  = '0;
        winners[i] = '0;
      end
      root     = '0;
      ways_reg = ltms_pkg::ACTIVE_RESET;
    endfunction

    // Clamp the register to the usable way count
    function int ways_used();
      if (ways_reg < 2) return 2;
      if (ways_reg > MaxWays) return MaxWays;
      return int'(ways_reg);
    endfunction

    // Smaller key wins, first argument on a tie
    function logic [WayW-1:0] better(logic [WayW-1:0] a, logic [WayW-1:0] b);
      return (keys[a] <= keys[b]) ? a : b;
    endfunction

    function logic [WayW-1:0] child_winner(int pos, int n);
      if (pos >= n) return WayW'(pos - n);
      return winners[pos % MaxWays];
    endfunction

    // Bottom-up build: left child wins ties
    function void rebuild();
      int n;
      int i;
      logic [WayW-1:0] l, r, w;
      n = ways_used();
      for (i = n - 1; i >= 1; i--) begin
        l = child_winner(2 * i, n);
        r = child_winner(2 * i + 1, n);
        w = better(l, r);
        winners[i] = w;
        losers[i]  = (w == l) ? r : l;
      end
      root = winners[1];
    endfunction

    // Climb from the winner's leaf: the stored loser wins ties
    function void replay(logic [WayW-1:0] p);
      int n;
      int pos;
      int node;
      logic [WayW-1:0] cur, kept, w;
      n   = ways_used();
      pos = n + int'(p);
      cur = p;
      while (pos / 2 >= 1) begin
        node = (pos / 2) % MaxWays;
        kept = losers[node];
        w    = better(kept, cur);
        losers[node]  = (w == kept) ? cur : kept;
        winners[node] = w;
        cur = w;
        pos = pos / 2;
      end
      root = winners[1];
    endfunction

    // Apply one accepted input transaction and queue the winner it produces
    function void take_input(logic [1:0] op, logic [WayW-1:0] way,
                             logic signed [KeyW-1:0] key);
      merge_result_t r;
      inputs_taken++;
      case (op)
        ltms_pkg::OP_LOAD: begin
          keys[way] = key;
          return;
        end
        ltms_pkg::OP_BUILD: begin
          rebuild();
        end
        ltms_pkg::OP_REPLACE: begin
          keys[root] = key;
          if (int'(root) >= ways_used()) rebuild();
          else replay(root);
        end
        default: begin
          return;
        end
      endcase
      r.way = root;
      r.key = keys[root];
      r.exh = (keys[root] == ltms_pkg::KEY_SENTINEL);
      pending_winners.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one result transaction against the oldest expected winner
    task check_winner(logic [WayW-1:0] way, logic signed [KeyW-1:0] key, logic exh);
      merge_result_t want;
      if (pending_winners.size() == 0) begin
        report($sformatf("unexpected result way %0d key %0d", way, key));
        return;
      end
      want = pending_winners.pop_front();
      results_checked++;
      if (want.exh) exhausted_checked++;
      if (way !== want.way)
        report($sformatf("winner_way %0d, expected %0d", way, want.way));
      if (key !== want.key)
        report($sformatf("winner_key %0d, expected %0d", key, want.key));
      if (exh !== want.exh)
        report($sformatf("exhausted %0b, expected %0b", exh, want.exh));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             operation_i = ltms_pkg::OP_LOAD;
  logic [WayW-1:0]        way_i = '0;
  logic signed [KeyW-1:0] key_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [WayW-1:0]        winner_way_o;
  logic signed [KeyW-1:0] winner_key_o;
  logic                   exhausted_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgW-1:0]        cfg_data_i = '0;

  winner_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cfg_writes = 0;

  loser_tree_merge_selector_top #(
    .MaxWays(MaxWays)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .way_i       (way_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .winner_way_o(winner_way_o),
    .winner_key_o(winner_key_o),
    .exhausted_o (exhausted_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_winner(winner_way_o, winner_key_o, exhausted_o);
  end

  task automatic set_pace(pace_e pace);
    case (pace)
      PACE_FULL: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        idle_pct  = 87;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        idle_pct  = 0;
        stall_pct = 87;
      end
      default: begin
        idle_pct  = 6;
        stall_pct = 6;
      end
    endcase
  endtask

  // Hold an input transaction until accepted, after a random idle gap
  task automatic send_item(logic [1:0] op, logic [WayW-1:0] way,
                           logic signed [KeyW-1:0] key);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    way_i       <= way;
    key_i       <= key;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_input(op, way, key);
  endtask

  // Write the way count; only called while the block is idle
  task automatic write_ways(logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.ways_reg = value;
    cfg_writes++;
  endtask

  // Drop valid, drain all owed winners, then let trailing work finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_winners.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key(key_spread_e spread);
    case (spread)
      SPREAD_NARROW: return KeyW'(int'($urandom_range(8)) - 4);
      SPREAD_WIDE:   return $urandom();
      default: begin
        case ($urandom_range(4))
          0:       return KEY_MIN;
          1:       return ltms_pkg::KEY_SENTINEL;
          2:       return -1;
          3:       return '0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Reset-time corners: every way loaded, replay before any build, ties, extremes
  task automatic run_directed();
    logic signed [KeyW-1:0] seed_keys [MaxWays];
    int w;
    seed_keys = '{32'sd0, KEY_MIN, ltms_pkg::KEY_SENTINEL, -32'sd1, 32'sd100, 32'sd100,
                  32'sh7FFF_FFFE, 32'sh8000_0001, 32'sd42, -32'sd42, 32'sd7, 32'sd7,
                  32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1, 32'sd2};
    for (w = 0; w < MaxWays; w++) send_item(ltms_pkg::OP_LOAD, WayW'(w), seed_keys[w]);
    send_item(ltms_pkg::OP_REPLACE, '0, 32'sd3);
    send_item(ltms_pkg::OP_BUILD, 4'hF, '0);
    send_item(OP_UNUSED, 4'hA, 32'sh1234_5678);
    send_item(ltms_pkg::OP_REPLACE, '0, KEY_MIN);
    send_item(ltms_pkg::OP_REPLACE, '0, ltms_pkg::KEY_SENTINEL);
    send_item(ltms_pkg::OP_REPLACE, '0, -32'sd1);
    send_item(ltms_pkg::OP_REPLACE, '0, ltms_pkg::KEY_SENTINEL);
    send_item(ltms_pkg::OP_LOAD, 4'hF, ltms_pkg::KEY_SENTINEL);
  endtask

  // One merge: usually load the active ways and build, then feed the winner until drained or out of replaces
  task automatic merge_round(inout int done);
    key_spread_e spread;
    logic signed [KeyW-1:0] cur;
    longint next_key;
    int n;
    int w;
    int reps;
    spread = key_spread_e'($urandom_range(2));
    n = sb.ways_used();
    if ($urandom_range(7) != 0) begin
      for (w = 0; w < n; w++) begin
        send_item(ltms_pkg::OP_LOAD, WayW'(w), pick_key(spread));
        done++;
      end
    end
    if ($urandom_range(5) != 0) begin
      send_item(ltms_pkg::OP_BUILD, WayW'($urandom()), pick_key(SPREAD_WIDE));
      done++;
    end
    reps = $urandom_range(4 * n, n);
    while (reps > 0 && sb.keys[sb.root] != ltms_pkg::KEY_SENTINEL) begin
      cur = sb.keys[sb.root];
      if ($urandom_range(3) == 0) begin
        next_key = ltms_pkg::KEY_SENTINEL;
      end else if (spread == SPREAD_NARROW) begin
        next_key = longint'(cur) + $urandom_range(3);
      end else begin
        next_key = longint'(cur) + $urandom_range(1000);
      end
      if (next_key > longint'(ltms_pkg::KEY_SENTINEL)) next_key = ltms_pkg::KEY_SENTINEL;
      send_item(ltms_pkg::OP_REPLACE, WayW'($urandom()), KeyW'(next_key));
      done++;
      reps--;
    end
  endtask

  // Random phase: mostly merges, some unstructured transactions
  task automatic run_phase(int count);
    int done;
    logic [1:0] op;
    done = 0;
    // replace first so stale nodes meet the new way count
    send_item(ltms_pkg::OP_REPLACE, WayW'($urandom()), pick_key(SPREAD_WIDE));
    done++;
    while (done < count) begin
      if ($urandom_range(9) < 7) begin
        merge_round(done);
      end else begin
        op = 2'($urandom_range(3));
        send_item(op, WayW'($urandom()), pick_key(key_spread_e'($urandom_range(2))));
        if (op != OP_UNUSED) done++;
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] plan [NumPhases];
    int p;
    plan = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd12, CfgW'($urandom_range(31))};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pace(PACE_FULL);
    run_directed();
    settle();

    for (p = 0; p < NumPhases; p++) begin
      set_pace(pace_e'(p % 4));
      write_ways(plan[p]);
      run_phase(PhaseItems);
      settle();
    end

    if (sb.pending_winners.size() != 0)
      sb.report($sformatf("%0d expected winners never arrived", sb.pending_winners.size()));
    $display("Ran %0d input transactions over %0d way-count settings; checked %0d winners,",
             sb.inputs_taken, cfg_writes + 1, sb.results_checked);
    $display("%0d of them exhausted, with full-rate, idle-sender and stalled-receiver pacing",
             sb.exhausted_checked);
    if (sb.mismatches == 0) begin
      $display("loser_tree_merge_selector_top test passed");
    end else begin
      $display("loser_tree_merge_selector_top test failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #10ms;
    $display("Timeout: block stopped accepting or returning transactions");
    $display("loser_tree_merge_selector_top test failed");
    $finish;
  end

endmodule
